// File: rtl/hfr_pkg.sv
package hfr_pkg;

   localparam int unsigned PAYLOAD_BYTES_DEFAULT = 7;
   localparam int unsigned PAYLOAD_W = 56;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_VALUE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_MODE   = 1'b1;

   localparam logic [1:0] MODE_FOLD135 = 2'd0;
   localparam logic [1:0] MODE_SUM     = 2'd1;
   localparam logic [1:0] MODE_FOLD119 = 2'd2;

   localparam logic [15:0] POLY_135 = 16'h0135;
   localparam logic [15:0] POLY_119 = 16'h0119;
   localparam logic [15:0] LIMIT_135 = 16'h007F;
   localparam logic [15:0] LIMIT_119 = 16'h00FF;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_DATA  = 2'd1,
      PH_CHECK = 2'd2
   } phase_type;

   typedef struct packed {
      logic                 valid;
      logic                 frame_ok;
      logic [PAYLOAD_W-1:0] payload;
      logic [7:0]           rx_check;
   } result_type;

   function automatic logic [15:0] fold_step(input logic [15:0] acc, input logic [7:0] b,
                                             input logic [15:0] limit,
                                             input logic [15:0] poly);
      logic [15:0] x;
      x = acc ^ {8'h00, b};
      x = {x[14:0], 1'b0};
      if (x > limit) begin
         x = x ^ poly;
      end
      return x;
   endfunction

endpackage

// File: rtl/hfr_req_if.sv
interface hfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/hfr_rsp_if.sv
interface hfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [55:0] payload;
   logic [7:0]  rx_check;

   modport source (output valid, output frame_ok, output payload, output rx_check, input ready);
   modport sink (input valid, input frame_ok, input payload, input rx_check, output ready);
endinterface

// File: rtl/hfr_parser.sv
module hfr_parser #(
   parameter int unsigned PAYLOAD_BYTES = hfr_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        header_value,
   input  logic [1:0]        check_mode,
   output logic              at_check,
   output hfr_pkg::result_type result
);
   import hfr_pkg::*;

   localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);
   localparam int unsigned FRAME_W = 8 * PAYLOAD_BYTES;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

   phase_type            phase_ff, phase_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [15:0]          acc135_ff, acc135_in;
   logic [15:0]          acc119_ff, acc119_in;
   logic [7:0]           sum_ff, sum_in;
   logic [7:0]           want;
   logic [63:0]          frame_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
      frame_ff  <= frame_in;
      acc135_ff <= acc135_in;
      acc119_ff <= acc119_in;
      sum_ff    <= sum_in;
   end

   always_comb begin
      priority if (check_mode == MODE_SUM) begin
         want = sum_ff;
      end else if (check_mode == MODE_FOLD119) begin
         want = acc119_ff[7:0] ^ frame_ff[7:0];
      end else begin
         want = acc135_ff[7:0] ^ frame_ff[FRAME_W-1 -: 8];
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      frame_in  = frame_ff;
      acc135_in = acc135_ff;
      acc119_in = acc119_ff;
      sum_in    = sum_ff;
      result.valid    = 1'b0;
      result.frame_ok = (want == rx_byte);
      result.payload  = frame_wide[PAYLOAD_W-1:0];
      result.rx_check = rx_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == header_value) begin
                  phase_in  = PH_DATA;
                  idx_in    = '0;
                  acc135_in = '0;
                  acc119_in = '0;
                  sum_in    = '0;
               end
            end
            PH_DATA: begin
               frame_in = {frame_ff[FRAME_W-9:0], rx_byte};
               sum_in   = sum_ff + rx_byte;
               if (idx_ff != '0) begin
                  acc135_in = fold_step(acc135_ff, rx_byte, LIMIT_135, POLY_135);
               end
               if (idx_ff != LAST_IDX) begin
                  acc119_in = fold_step(acc119_ff, rx_byte, LIMIT_119, POLY_119);
                  idx_in    = idx_ff + 1'b1;
               end else begin
                  phase_in = PH_CHECK;
                  idx_in   = '0;
               end
            end
            PH_CHECK: begin
               result.valid = 1'b1;
               phase_in     = PH_HUNT;
               idx_in       = '0;
            end
            default: begin
               phase_in = PH_HUNT;
               idx_in   = '0;
            end
         endcase
      end
   end

   assign frame_wide      = 64'(frame_ff);
   assign at_check        = (phase_ff == PH_CHECK);

`ifndef SYNTHESIS
   a_check_idx_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CHECK |-> idx_ff == '0)
      else $error("index not cleared at check byte");

   a_check_to_hunt: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_CHECK |=> phase_ff == PH_HUNT)
      else $error("no return to hunting after check byte");

   a_last_to_check: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_DATA && idx_ff == LAST_IDX |=> phase_ff == PH_CHECK)
      else $error("last payload byte did not lead to check phase");

   a_result_only_check: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> accept && at_check)
      else $error("result outside check phase");
`endif

endmodule

// File: rtl/hfr_out.sv
module hfr_out (
   input  logic                clock,
   input  logic                reset,
   input  hfr_pkg::result_type result,
   output logic                full,
   hfr_rsp_if.source           rsp_chan
);
   import hfr_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 ok_ff, ok_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [7:0]           check_ff, check_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ok_ff      <= ok_in;
      payload_ff <= payload_in;
      check_ff   <= check_in;
   end

   always_comb begin
      valid_in   = valid_ff && !rsp_chan.ready;
      ok_in      = ok_ff;
      payload_in = payload_ff;
      check_in   = check_ff;
      if (result.valid) begin
         valid_in   = 1'b1;
         ok_in      = result.frame_ok;
         payload_in = result.payload;
         check_in   = result.rx_check;
      end
   end

   assign full              = valid_ff && !rsp_chan.ready;
   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.frame_ok = ok_ff;
   assign rsp_chan.payload  = payload_ff;
   assign rsp_chan.rx_check = check_ff;

endmodule

// File: rtl/handle_frame_receiver.sv
// Header-framed byte receiver with a selectable 8-bit check. Bytes enter on req_chan
// one per cycle; the block hunts for header_value (csr index 0), stores PAYLOAD_BYTES
// payload bytes and treats the next byte as the check byte, compared with a check
// picked by check_mode (csr index 1): 0 or 3 fold with 0x135, 1 byte sum, 2 fold with
// 0x119. All three checks are built in parallel, so any mode written before the
// check byte applies. Only the check byte gives a response, on rsp_chan in the next
// cycle, with frame_ok, the payload (first byte on top) and the received check byte.
// Throughput is one byte per cycle; req_chan.ready drops only while a check byte is
// waiting and the response register still holds an untaken response.
module handle_frame_receiver #(
   parameter int unsigned PAYLOAD_BYTES = hfr_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   hfr_req_if.sink                          req_chan,
   hfr_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [hfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hfr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hfr_pkg::*;

   logic [7:0]  header_ff, header_in;
   logic [1:0]  mode_ff, mode_in;
   logic        at_check;
   logic        out_full;
   logic        accept;
   result_type  result;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
         mode_ff   <= MODE_FOLD135;
      end else begin
         header_ff <= header_in;
         mode_ff   <= mode_in;
      end
   end

   always_comb begin
      header_in = header_ff;
      mode_in   = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_VALUE: header_in = csr_wdata;
            CSR_CHECK_MODE:   mode_in   = csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready = !(at_check && out_full);
   assign accept         = req_chan.valid && req_chan.ready;

   hfr_parser #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_chan.rx_byte),
      .header_value (header_ff),
      .check_mode   (mode_ff),
      .at_check     (at_check),
      .result       (result)
   );

   hfr_out u_out (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .full     (out_full),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import hfr_pkg::*;

   localparam int PERIOD = 12;
   localparam int FRAME_BYTES = 7;
   localparam int LONG_HOLD = 80;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [15:0] FOLD_A_POLY = 16'h0135;
   localparam logic [15:0] FOLD_A_TOP  = 16'h007F;
   localparam logic [15:0] FOLD_B_POLY = 16'h0119;
   localparam logic [15:0] FOLD_B_TOP  = 16'h00FF;

   typedef logic [7:0] frame_bytes_type [FRAME_BYTES];

   typedef struct {
      logic                 ok;
      logic [PAYLOAD_W-1:0] payload;
      logic [7:0]           chk;
   } frame_verdict_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   hfr_req_if req_chan();
   hfr_rsp_if rsp_chan();

   handle_frame_receiver uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // configuration as the block holds it
   logic [7:0] cfg_header = 8'h00;
   logic [1:0] cfg_mode = MODE_FOLD135;

   // receiver state
   phase_type       rx_phase = PH_HUNT;
   int              rx_count = 0;
   frame_bytes_type rx_store;

   logic [7:0]        pending_bytes[$];
   frame_verdict_type awaited_verdicts[$];
   int             pushed = 0;
   int             mismatches = 0;
   bit             req_taken = 1'b0;
   bit             quiet = 1'b0;
   int             req_gap = 0;
   int             rsp_gap = 0;
   int             hold_left = 0;
   int             hold_asks = 0;
   int             hold_done = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready = 1'b0;
   end

   always #(PERIOD / 2) clock = ~clock;

   function automatic logic [7:0] frame_check(input frame_bytes_type b, input logic [1:0] mode);
      logic [15:0] acc;
      logic [7:0]  sum;
      acc = '0;
      sum = '0;
      if (mode == MODE_SUM) begin
         for (int k = 0; k < FRAME_BYTES; k++) sum = sum + b[k];
         return sum;
      end
      if (mode == MODE_FOLD119) begin
         for (int k = 0; k < FRAME_BYTES - 1; k++) begin
            acc = (acc ^ {8'h00, b[k]}) << 1;
            if (acc > FOLD_B_TOP) acc = acc ^ FOLD_B_POLY;
         end
         return acc[7:0] ^ b[FRAME_BYTES-1];
      end
      for (int k = 1; k < FRAME_BYTES; k++) begin
         acc = (acc ^ {8'h00, b[k]}) << 1;
         if (acc > FOLD_A_TOP) acc = acc ^ FOLD_A_POLY;
      end
      return acc[7:0] ^ b[0];
   endfunction

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      frame_verdict_type v;
      case (rx_phase)
         PH_HUNT: begin
            if (b == cfg_header) begin
               rx_phase = PH_DATA;
               rx_count = 0;
            end
         end
         PH_DATA: begin
            rx_store[rx_count] = b;
            rx_count++;
            if (rx_count == FRAME_BYTES) begin
               rx_phase = PH_CHECK;
               rx_count = 0;
            end
         end
         PH_CHECK: begin
            v.ok = (frame_check(rx_store, cfg_mode) == b);
            v.payload = '0;
            for (int k = 0; k < FRAME_BYTES; k++) v.payload = {v.payload[PAYLOAD_W-9:0], rx_store[k]};
            v.chk = b;
            awaited_verdicts.push_back(v);
            rx_phase = PH_HUNT;
            rx_count = 0;
         end
         default: begin
            rx_phase = PH_HUNT;
            rx_count = 0;
         end
      endcase
   endtask

   task automatic check_verdict();
      frame_verdict_type v;
      if (awaited_verdicts.size() == 0) begin
         note_mismatch($sformatf("unexpected response ok=%0b payload=%h check=%h",
                                 rsp_chan.frame_ok, rsp_chan.payload, rsp_chan.rx_check));
         return;
      end
      v = awaited_verdicts.pop_front();
      if (rsp_chan.frame_ok !== v.ok || rsp_chan.payload !== v.payload ||
          rsp_chan.rx_check !== v.chk) begin
         note_mismatch($sformatf({"response mismatch: expected ok=%0b payload=%h check=%h,",
                                  " got ok=%0b payload=%h check=%h"},
                                 v.ok, v.payload, v.chk,
                                 rsp_chan.frame_ok, rsp_chan.payload, rsp_chan.rx_check));
      end
   endtask

   // monitor: requests feed the predictor, responses are checked in order
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_chan.valid && req_chan.ready;
         if (req_taken) absorb_byte(req_chan.rx_byte);
         if (rsp_chan.valid && rsp_chan.ready) check_verdict();
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_bytes.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 9);
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.rx_byte <= pending_bytes.pop_front();
            req_chan.valid <= 1'b1;
         end
      end
   end

   // response ready, with random stalls and the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (hold_done != hold_asks) begin
         hold_done++;
         hold_left = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 9);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      pushed++;
   endtask

   task automatic queue_frame(input logic [7:0] hdr, input frame_bytes_type fb, input bit good);
      logic [7:0] chk;
      chk = frame_check(fb, cfg_mode);
      if (!good) chk = chk ^ 8'($urandom_range(1, 255));
      push_byte(hdr);
      for (int k = 0; k < FRAME_BYTES; k++) push_byte(fb[k]);
      push_byte(chk);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_HEADER_VALUE) cfg_header = val;
      else cfg_mode = val[1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] hdr, input logic [1:0] mode);
      csr_write(CSR_HEADER_VALUE, hdr);
      csr_write(CSR_CHECK_MODE, {6'b0, mode});
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0 || req_chan.valid || awaited_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly well-formed frames, some noise and truncated frames
   task automatic random_phase(input int n);
      frame_bytes_type fb;
      int              stop_at;
      stop_at = pushed + n;
      while (pushed < stop_at) begin
         case ($urandom_range(0, 9))
            0: push_byte(8'($urandom_range(0, 255)));
            1: begin
               push_byte(cfg_header);
               repeat ($urandom_range(0, FRAME_BYTES - 1)) push_byte(random_byte());
            end
            default: begin
               for (int k = 0; k < FRAME_BYTES; k++) fb[k] = random_byte();
               queue_frame(cfg_header, fb, $urandom_range(0, 4) != 0);
            end
         endcase
      end
   endtask

   initial begin
      frame_bytes_type fb;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: non-header bytes dropped, good and bad frames, then half a frame
      push_byte(8'hFF);
      push_byte(8'h01);
      fb = '{default: 8'hFF};
      queue_frame(8'h00, fb, 1'b1);
      fb = '{default: 8'h00};
      queue_frame(8'h00, fb, 1'b0);
      push_byte(8'h00);
      push_byte(8'h12);
      push_byte(8'h34);
      push_byte(8'h56);
      drain();

      // mode switched while the frame is open
      csr_write(CSR_CHECK_MODE, {6'b0, MODE_SUM});
      fb = '{8'h12, 8'h34, 8'h56, 8'h80, 8'h7F, 8'h01, 8'hFE};
      for (int k = 3; k < FRAME_BYTES; k++) push_byte(fb[k]);
      push_byte(frame_check(fb, MODE_SUM));
      drain();

      set_config(8'hFF, MODE_FOLD119);
      random_phase(200);
      drain();
      set_config(8'h00, MODE_FOLD135);
      random_phase(200);
      drain();
      set_config(8'hA5, MODE_SUM);
      random_phase(200);
      hold_asks++;
      drain();
      set_config(8'h80, MODE_SPARE);
      random_phase(200);
      drain();
      set_config(8'h5A, MODE_FOLD119);
      random_phase(200);
      drain();
      quiet = 1'b1;
      set_config(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
      random_phase(200);
      drain();
      repeat (8) @(posedge clock);

      if (mismatches == 0 && awaited_verdicts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(PERIOD * 300000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/hfr_pkg.sv
rtl/hfr_req_if.sv
rtl/hfr_rsp_if.sv
rtl/hfr_parser.sv
rtl/hfr_out.sv
rtl/handle_frame_receiver.sv
verif/testbench.sv
